@@ rtl/core/prmf_pkg.sv @@
// Shared types and constants for the push-relabel maximum flow block.
package prmf_pkg;

   localparam int CMD_W  = 2;
   localparam int NODE_W = 6;
   localparam int CAPI_W = 16;
   localparam int FLOW_W = 32;
   localparam int EXC_W  = 33;
   localparam int CFG_W  = 7;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

   typedef enum logic [1:0] {
      ALU_ADD32,
      ALU_ADD33,
      ALU_SUB,
      ALU_LT
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_WIPE,
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_COPY,
      ST_SRC_RD,
      ST_SRC_CHK,
      ST_SRC_REV_RD,
      ST_SRC_REV_WR,
      ST_PI_RD,
      ST_PI_CHK,
      ST_PJ_RD,
      ST_PJ_CHK,
      ST_PU_FWD,
      ST_PU_EXI,
      ST_PU_REV,
      ST_PU_EXJ,
      ST_RI_RD,
      ST_RI_CHK,
      ST_RJ_RD,
      ST_RJ_CHK,
      ST_DONE_RD,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/prmf_req_if.sv @@
// Request channel interface carrying command transactions.
interface prmf_req_if;
   logic                           valid;
   logic                           ready;
   logic [prmf_pkg::CMD_W-1:0]     cmd;
   logic [prmf_pkg::NODE_W-1:0]    from_node;
   logic [prmf_pkg::NODE_W-1:0]    to_node;
   logic [prmf_pkg::CAPI_W-1:0]    edge_capacity;

   modport source (output valid, cmd, from_node, to_node, edge_capacity, input ready);
   modport sink   (input valid, cmd, from_node, to_node, edge_capacity, output ready);
endinterface

@@ rtl/core/prmf_rsp_if.sv @@
// Response channel interface carrying flow results.
interface prmf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [prmf_pkg::FLOW_W-1:0]    max_flow;
   logic                           saturated;

   modport source (output valid, max_flow, saturated, input ready);
   modport sink   (input valid, max_flow, saturated, output ready);
endinterface

@@ rtl/core/prmf_csr_if.sv @@
// Configuration write channel interface for the node count register.
interface prmf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [prmf_pkg::CFG_W-1:0]     node_count;

   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

@@ rtl/core/prmf_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module prmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/prmf_alu.sv @@
// Shared arithmetic unit: saturating adds, subtract and compare.
module prmf_alu (
   input  prmf_pkg::alu_op_type          op,
   input  logic [prmf_pkg::EXC_W-1:0]    a,
   input  logic [prmf_pkg::EXC_W-1:0]    b,
   output logic [prmf_pkg::EXC_W-1:0]    y,
   output logic                          sat,
   output logic                          lt
);
   logic [prmf_pkg::EXC_W:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};
   assign lt  = (a < b);

   always_comb begin
      y   = '0;
      sat = 1'b0;
      case (op)
         prmf_pkg::ALU_ADD32: begin
            if (sum[prmf_pkg::EXC_W:prmf_pkg::FLOW_W] != '0) begin
               y   = {1'b0, {prmf_pkg::FLOW_W{1'b1}}};
               sat = 1'b1;
            end else begin
               y = sum[prmf_pkg::EXC_W-1:0];
            end
         end
         prmf_pkg::ALU_ADD33: begin
            if (sum[prmf_pkg::EXC_W]) begin
               y   = '1;
               sat = 1'b1;
            end else begin
               y = sum[prmf_pkg::EXC_W-1:0];
            end
         end
         prmf_pkg::ALU_SUB: begin
            y = a - b;
         end
         default: begin
            y = '0;
         end
      endcase
   end
endmodule

@@ rtl/core/push_relabel_max_flow.sv @@
// Top level: push-relabel maximum flow sequencer with capacity and residual stores.
// A clear sweeps the capacity store to zero; an edge transaction reads its capacity
// entry and writes back the sum; a run copies the capacity store into the residual
// store, saturates the source edges, then walks node scans and pushes until no inner
// node holds excess. Throughput is one transaction at a time; the stores set the pace.
// After reset the capacity store is swept to zero.
module push_relabel_max_flow #(
   parameter int MAX_NODES     = 64,
   parameter int CAPACITY_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   prmf_req_if.sink            req_chan,
   prmf_rsp_if.source          rsp_chan,
   prmf_csr_if.sink            csr_chan
);
   // Node index width, loop counter width and store address width.
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int AW = 2 * NW;
   localparam int KW = AW + 1;
   localparam int NN = 1 << NW;
   localparam int DEPTH = 1 << AW;
   // Heights never exceed twice the node count.
   localparam int HW = $clog2(2 * MAX_NODES) + 1;
   localparam int FW = prmf_pkg::FLOW_W;
   localparam int EW = prmf_pkg::EXC_W;

   prmf_pkg::state_type state_ff, state_in;

   // Control registers.
   logic [KW-1:0]                 k_ff, k_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          ovf_ff, ovf_in;
   logic                          rsat_ff, rsat_in;
   logic [prmf_pkg::CFG_W-1:0]    node_count_ff;

   // Working registers of the run.
   logic [CW-1:0]                 i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [NW-1:0]                 a_ff, a_in, b_ff, b_in;
   logic [prmf_pkg::CAPI_W-1:0]   c_ff, c_in;
   logic [HW-1:0]                 hi_ff, hi_in, low_ff, low_in;
   logic [EW-1:0]                 ei_ff, ei_in;
   logic [FW-1:0]                 r_ff, r_in, d_ff, d_in;
   logic                          lift_ff, lift_in;
   logic [FW-1:0]                 flow_ff, flow_in;
   logic                          sat_ff, sat_in;

   // Store ports.
   logic                cap_we, res_we, h_we, ex_we;
   logic [AW-1:0]       cap_waddr, cap_raddr, res_waddr, res_raddr;
   logic [FW-1:0]       cap_wdata, cap_q, res_wdata, res_q;
   logic [NW-1:0]       h_waddr, h_raddr, ex_waddr, ex_raddr;
   logic [HW-1:0]       h_wdata, h_q;
   logic [EW-1:0]       ex_wdata, ex_q;

   // Shared arithmetic unit.
   prmf_pkg::alu_op_type alu_op;
   logic [EW-1:0]        alu_a, alu_b, alu_y;
   logic                 alu_sat, alu_lt;

   logic                          req_fire, rsp_fire, edge_ok;
   logic [8:0]                    from_ext, to_ext, ncfg_ext, n_clamp;
   logic [prmf_pkg::CAPI_W-1:0]   cap_mask;
   logic [NW-1:0]                 i_idx, j_idx;
   logic                          i_last, j_end, admissible;
   logic [CW-1:0]                 n_m1;
   logic [KW-1:0]                 k_m1;

   assign req_chan.ready = (state_ff == prmf_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.max_flow  = flow_ff;
   assign rsp_chan.saturated = sat_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;

   // Edges touching nodes at or above MAX_NODES, and self loops, are dropped.
   assign from_ext = 9'(req_chan.from_node);
   assign to_ext   = 9'(req_chan.to_node);
   assign edge_ok  = (from_ext < 9'(MAX_NODES)) && (to_ext < 9'(MAX_NODES))
                     && (from_ext != to_ext);
   assign cap_mask = prmf_pkg::CAPI_W'((33'd1 << CAPACITY_BITS) - 33'd1);

   // The node count register is clamped into the supported range at run start.
   assign ncfg_ext = 9'(node_count_ff);
   assign n_clamp  = (ncfg_ext < 9'd2) ? 9'd2 :
                     (ncfg_ext > 9'(MAX_NODES)) ? 9'(MAX_NODES) : ncfg_ext;

   assign i_idx  = i_ff[NW-1:0];
   assign j_idx  = j_ff[NW-1:0];
   assign n_m1   = CW'(n_ff - CW'(1));
   assign i_last = (i_ff == n_m1);
   assign j_end  = (j_ff == n_ff);
   assign k_m1   = KW'(k_ff - KW'(1));
   assign admissible = (res_q != '0) &&
                       ((HW + 1)'(hi_ff) == (HW + 1)'(h_q) + (HW + 1)'(1));

   prmf_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .y   (alu_y),
      .sat (alu_sat),
      .lt  (alu_lt)
   );

   // Capacity store: accumulated edge capacities, kept across runs.
   prmf_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_waddr),
      .wr_data (cap_wdata),
      .rd_addr (cap_raddr),
      .rd_data (cap_q)
   );

   // Residual store: rebuilt from the capacity store at every run.
   prmf_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_addr (res_raddr),
      .rd_data (res_q)
   );

   prmf_ram #(.WIDTH(HW), .DEPTH(NN)) u_height_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_q)
   );

   prmf_ram #(.WIDTH(EW), .DEPTH(NN)) u_excess_ram (
      .clock   (clock),
      .wr_en   (ex_we),
      .wr_addr (ex_waddr),
      .wr_data (ex_wdata),
      .rd_addr (ex_raddr),
      .rd_data (ex_q)
   );

   // Next state. Push scans restart from the first inner node after every push
   // or relabel, which keeps the order of operations identical to the
   // generic algorithm's first-active-node rule.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prmf_pkg::ST_WIPE: begin
            if (k_ff == KW'(DEPTH - 1)) state_in = prmf_pkg::ST_IDLE;
         end
         prmf_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.cmd)
                  prmf_pkg::CMD_CLEAR: state_in = prmf_pkg::ST_WIPE;
                  prmf_pkg::CMD_EDGE: begin
                     if (edge_ok) state_in = prmf_pkg::ST_EDGE_RD;
                  end
                  prmf_pkg::CMD_RUN:   state_in = prmf_pkg::ST_COPY;
                  default:             state_in = prmf_pkg::ST_IDLE;
               endcase
            end
         end
         prmf_pkg::ST_EDGE_RD:    state_in = prmf_pkg::ST_EDGE_WR;
         prmf_pkg::ST_EDGE_WR:    state_in = prmf_pkg::ST_IDLE;
         prmf_pkg::ST_COPY: begin
            if (k_ff == KW'(DEPTH)) state_in = prmf_pkg::ST_SRC_RD;
         end
         prmf_pkg::ST_SRC_RD: begin
            state_in = j_end ? prmf_pkg::ST_PI_RD : prmf_pkg::ST_SRC_CHK;
         end
         prmf_pkg::ST_SRC_CHK: begin
            state_in = (res_q == '0) ? prmf_pkg::ST_SRC_RD : prmf_pkg::ST_SRC_REV_RD;
         end
         prmf_pkg::ST_SRC_REV_RD: state_in = prmf_pkg::ST_SRC_REV_WR;
         prmf_pkg::ST_SRC_REV_WR: state_in = prmf_pkg::ST_SRC_RD;
         prmf_pkg::ST_PI_RD: begin
            state_in = i_last ? prmf_pkg::ST_RI_RD : prmf_pkg::ST_PI_CHK;
         end
         prmf_pkg::ST_PI_CHK: begin
            state_in = (ex_q == '0) ? prmf_pkg::ST_PI_RD : prmf_pkg::ST_PJ_RD;
         end
         prmf_pkg::ST_PJ_RD: begin
            state_in = j_end ? prmf_pkg::ST_PI_RD : prmf_pkg::ST_PJ_CHK;
         end
         prmf_pkg::ST_PJ_CHK: begin
            state_in = admissible ? prmf_pkg::ST_PU_FWD : prmf_pkg::ST_PJ_RD;
         end
         prmf_pkg::ST_PU_FWD:     state_in = prmf_pkg::ST_PU_EXI;
         prmf_pkg::ST_PU_EXI:     state_in = prmf_pkg::ST_PU_REV;
         prmf_pkg::ST_PU_REV:     state_in = prmf_pkg::ST_PU_EXJ;
         prmf_pkg::ST_PU_EXJ:     state_in = prmf_pkg::ST_PI_RD;
         prmf_pkg::ST_RI_RD: begin
            state_in = i_last ? prmf_pkg::ST_DONE_RD : prmf_pkg::ST_RI_CHK;
         end
         prmf_pkg::ST_RI_CHK: begin
            state_in = (ex_q == '0) ? prmf_pkg::ST_RI_RD : prmf_pkg::ST_RJ_RD;
         end
         prmf_pkg::ST_RJ_RD: begin
            if (j_end) begin
               state_in = lift_ff ? prmf_pkg::ST_PI_RD : prmf_pkg::ST_RI_RD;
            end else begin
               state_in = prmf_pkg::ST_RJ_CHK;
            end
         end
         prmf_pkg::ST_RJ_CHK:     state_in = prmf_pkg::ST_RJ_RD;
         prmf_pkg::ST_DONE_RD:    state_in = prmf_pkg::ST_DONE;
         prmf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = prmf_pkg::ST_IDLE;
         end
         default:                 state_in = prmf_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register updates for each state.
   always_comb begin
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      ovf_in       = ovf_ff;
      rsat_in      = rsat_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      hi_in        = hi_ff;
      low_in       = low_ff;
      ei_in        = ei_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      lift_in      = lift_ff;
      flow_in      = flow_ff;
      sat_in       = sat_ff;

      cap_we    = 1'b0;
      cap_waddr = {a_ff, b_ff};
      cap_wdata = alu_y[FW-1:0];
      cap_raddr = {a_ff, b_ff};
      res_we    = 1'b0;
      res_waddr = {i_idx, j_idx};
      res_wdata = alu_y[FW-1:0];
      res_raddr = {i_idx, j_idx};
      h_we      = 1'b0;
      h_waddr   = i_idx;
      h_wdata   = HW'(low_ff + HW'(1));
      h_raddr   = i_idx;
      ex_we     = 1'b0;
      ex_waddr  = i_idx;
      ex_wdata  = alu_y;
      ex_raddr  = i_idx;
      alu_op    = prmf_pkg::ALU_ADD32;
      alu_a     = '0;
      alu_b     = '0;

      if (rsp_fire) rsp_valid_in = 1'b0;

      case (state_ff)
         prmf_pkg::ST_WIPE: begin
            cap_we    = 1'b1;
            cap_waddr = k_ff[AW-1:0];
            cap_wdata = '0;
            k_in      = KW'(k_ff + KW'(1));
         end
         prmf_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.cmd)
                  prmf_pkg::CMD_CLEAR: begin
                     ovf_in = 1'b0;
                     k_in   = '0;
                  end
                  prmf_pkg::CMD_EDGE: begin
                     a_in = from_ext[NW-1:0];
                     b_in = to_ext[NW-1:0];
                     c_in = req_chan.edge_capacity & cap_mask;
                  end
                  prmf_pkg::CMD_RUN: begin
                     n_in    = CW'(n_clamp);
                     rsat_in = 1'b0;
                     k_in    = '0;
                  end
                  default: begin
                     k_in = k_ff;
                  end
               endcase
            end
         end
         prmf_pkg::ST_EDGE_RD: begin
            cap_raddr = {a_ff, b_ff};
         end
         prmf_pkg::ST_EDGE_WR: begin
            alu_op = prmf_pkg::ALU_ADD32;
            alu_a  = EW'(cap_q);
            alu_b  = EW'(c_ff);
            cap_we = 1'b1;
            if (alu_sat) ovf_in = 1'b1;
         end
         prmf_pkg::ST_COPY: begin
            // Read runs one entry ahead of the write.
            cap_raddr = k_ff[AW-1:0];
            if (k_ff != '0) begin
               res_we    = 1'b1;
               res_waddr = k_m1[AW-1:0];
               res_wdata = cap_q;
            end
            if (k_ff < KW'(NN)) begin
               h_we     = 1'b1;
               h_waddr  = k_ff[NW-1:0];
               h_wdata  = (k_ff == '0) ? HW'(n_ff) : '0;
               ex_we    = 1'b1;
               ex_waddr = k_ff[NW-1:0];
               ex_wdata = '0;
            end
            k_in = KW'(k_ff + KW'(1));
            j_in = CW'(1);
         end
         prmf_pkg::ST_SRC_RD: begin
            res_raddr = {NW'(0), j_idx};
            if (j_end) i_in = CW'(1);
         end
         prmf_pkg::ST_SRC_CHK: begin
            if (res_q == '0) begin
               j_in = CW'(j_ff + CW'(1));
            end else begin
               // Saturate the source edge: its forward residual drops to zero.
               r_in      = res_q;
               res_we    = 1'b1;
               res_waddr = {NW'(0), j_idx};
               res_wdata = '0;
            end
         end
         prmf_pkg::ST_SRC_REV_RD: begin
            res_raddr = {j_idx, NW'(0)};
         end
         prmf_pkg::ST_SRC_REV_WR: begin
            alu_op    = prmf_pkg::ALU_ADD32;
            alu_a     = EW'(res_q);
            alu_b     = EW'(r_ff);
            res_we    = 1'b1;
            res_waddr = {j_idx, NW'(0)};
            if (alu_sat) rsat_in = 1'b1;
            ex_we     = 1'b1;
            ex_waddr  = j_idx;
            ex_wdata  = EW'(r_ff);
            j_in      = CW'(j_ff + CW'(1));
         end
         prmf_pkg::ST_PI_RD: begin
            ex_raddr = i_idx;
            h_raddr  = i_idx;
            if (i_last) i_in = CW'(1);
         end
         prmf_pkg::ST_PI_CHK: begin
            if (ex_q == '0) begin
               i_in = CW'(i_ff + CW'(1));
            end else begin
               ei_in = ex_q;
               hi_in = h_q;
               j_in  = '0;
            end
         end
         prmf_pkg::ST_PJ_RD: begin
            res_raddr = {i_idx, j_idx};
            h_raddr   = j_idx;
            if (j_end) i_in = CW'(i_ff + CW'(1));
         end
         prmf_pkg::ST_PJ_CHK: begin
            // The amount pushed is the smaller of excess and residual.
            alu_op = prmf_pkg::ALU_LT;
            alu_a  = ei_ff;
            alu_b  = EW'(res_q);
            if (admissible) begin
               r_in = res_q;
               d_in = alu_lt ? ei_ff[FW-1:0] : res_q;
            end else begin
               j_in = CW'(j_ff + CW'(1));
            end
         end
         prmf_pkg::ST_PU_FWD: begin
            alu_op    = prmf_pkg::ALU_SUB;
            alu_a     = EW'(r_ff);
            alu_b     = EW'(d_ff);
            res_we    = 1'b1;
            res_waddr = {i_idx, j_idx};
         end
         prmf_pkg::ST_PU_EXI: begin
            alu_op    = prmf_pkg::ALU_SUB;
            alu_a     = ei_ff;
            alu_b     = EW'(d_ff);
            ex_we     = 1'b1;
            ex_waddr  = i_idx;
            res_raddr = {j_idx, i_idx};
            ex_raddr  = j_idx;
         end
         prmf_pkg::ST_PU_REV: begin
            alu_op    = prmf_pkg::ALU_ADD32;
            alu_a     = EW'(res_q);
            alu_b     = EW'(d_ff);
            res_we    = 1'b1;
            res_waddr = {j_idx, i_idx};
            ex_raddr  = j_idx;
            if (alu_sat) rsat_in = 1'b1;
         end
         prmf_pkg::ST_PU_EXJ: begin
            alu_op   = prmf_pkg::ALU_ADD33;
            alu_a    = ex_q;
            alu_b    = EW'(d_ff);
            ex_we    = 1'b1;
            ex_waddr = j_idx;
            if (alu_sat) rsat_in = 1'b1;
            i_in     = CW'(1);
         end
         prmf_pkg::ST_RI_RD: begin
            ex_raddr = i_idx;
            h_raddr  = i_idx;
         end
         prmf_pkg::ST_RI_CHK: begin
            if (ex_q == '0) begin
               i_in = CW'(i_ff + CW'(1));
            end else begin
               hi_in   = h_q;
               lift_in = 1'b0;
               low_in  = '1;
               j_in    = '0;
            end
         end
         prmf_pkg::ST_RJ_RD: begin
            res_raddr = {i_idx, j_idx};
            h_raddr   = j_idx;
            if (j_end) begin
               if (lift_ff) begin
                  h_we    = 1'b1;
                  h_waddr = i_idx;
                  i_in    = CW'(1);
               end else begin
                  i_in = CW'(i_ff + CW'(1));
               end
            end
         end
         prmf_pkg::ST_RJ_CHK: begin
            if (res_q != '0) begin
               if (h_q >= hi_ff) lift_in = 1'b1;
               if (h_q < low_ff) low_in = h_q;
            end
            j_in = CW'(j_ff + CW'(1));
         end
         prmf_pkg::ST_DONE_RD: begin
            ex_raddr = n_m1[NW-1:0];
         end
         prmf_pkg::ST_DONE: begin
            ex_raddr = n_m1[NW-1:0];
            if (!rsp_valid_ff || rsp_chan.ready) begin
               // Sink excess beyond 32 bits is clamped and flagged.
               rsp_valid_in = 1'b1;
               flow_in      = ex_q[FW] ? '1 : ex_q[FW-1:0];
               sat_in       = ovf_ff || rsat_ff || ex_q[FW];
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prmf_pkg::ST_WIPE;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         ovf_ff        <= 1'b0;
         rsat_ff       <= 1'b0;
         node_count_ff <= prmf_pkg::CFG_W'(2);
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         ovf_ff       <= ovf_in;
         rsat_ff      <= rsat_in;
         if (csr_chan.valid && csr_chan.ready) begin
            node_count_ff <= csr_chan.node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      hi_ff   <= hi_in;
      low_ff  <= low_in;
      ei_ff   <= ei_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      lift_ff <= lift_in;
      flow_ff <= flow_in;
      sat_ff  <= sat_in;
   end
endmodule
